/* sv/tfve_pkg.sv */
// ----------------------------------------------------------------------------
// tfve_pkg
// Shared types, codes and constants of the flick velocity estimator.
// ----------------------------------------------------------------------------
package tfve_pkg;

  localparam int unsigned HISTORY_DEPTH = 8;
  localparam int unsigned WINDOW        = 5;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned GAIN_W  = 11;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned PROP_W  = 10;
  localparam int unsigned VEL_W   = 17;
  localparam int unsigned OP_W    = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 40;

  // |d| * 1000 stays below 2^26
  localparam int unsigned DIV_W  = 26;
  // |elapsed| stays below 2^33
  localparam int unsigned ELAP_W = 34;
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned GAIN_FRAC_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FLICK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLICK_MAX_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPAGATION_MS  = 2'd2;

  localparam logic [SPEED_W-1:0] THRESHOLD_RST = 16'd500;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd9000;
  localparam logic [PROP_W-1:0]  PROP_RST      = 10'd0;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH_DOWN   = 2'd0,
    OP_TOUCH_MOVE   = 2'd1,
    OP_SECOND_DOWN  = 2'd2,
    OP_FLICK        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_NEW,
    ST_RD_OLD,
    ST_DIFF,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

endpackage

/* sv/tfve_ram.sv */
// ----------------------------------------------------------------------------
// tfve_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfve_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/touch_flick_velocity_estimator.sv */
// ----------------------------------------------------------------------------
// touch_flick_velocity_estimator
// Records touch samples in a ring and estimates flick velocity on request.
// ----------------------------------------------------------------------------
// Touch down, move and second-finger-down transactions are handled in ST_IDLE.
// A flick request that finds recording on and at least two samples occupies
// the block after acceptance: two ring reads (ST_RD_NEW, ST_RD_OLD), the
// set-up states ST_DIFF and ST_PREP, the bit-serial restoring divider (one
// quotient bit per cycle for both axes), the serial gain multiply (one gain
// bit per cycle) and the shaping state ST_OUT; any other flick request leaves
// the block in ST_IDLE. The ring sits in a RAM with one read port, so the two
// samples are fetched in turn. A result waits in the output register while
// new samples are accepted; a following flick waits in ST_OUT until that
// register is free. Configuration is written through cfg_we_i, cfg_idx_i, cfg_data_i.
// ----------------------------------------------------------------------------
module touch_flick_velocity_estimator #(
  parameter int unsigned HistoryDepth = tfve_pkg::HISTORY_DEPTH,
  parameter int unsigned Window       = tfve_pkg::WINDOW
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pos_x [15:0], pos_y [31:16], time_ms [63:32], gain [74:64], zero pad
  input  logic [tfve_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // operation [1:0]
  input  logic [tfve_pkg::OP_W-1:0]            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // velocity_x [16:0], velocity_y [33:17], zero pad
  output logic [tfve_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [tfve_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tfve_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(HistoryDepth);
  localparam int unsigned CntW  = $clog2(HistoryDepth + 1);
  localparam int unsigned WrapW = IdxW + 1;
  localparam int unsigned Span  = (Window < HistoryDepth) ? Window : HistoryDepth;
  localparam int unsigned RamW  = 2 * tfve_pkg::POS_W + tfve_pkg::TIME_W;
  localparam int unsigned DivW  = tfve_pkg::DIV_W;
  localparam int unsigned ElapW = tfve_pkg::ELAP_W;
  localparam int unsigned DsrW  = ElapW - 1;
  localparam int unsigned GainW = tfve_pkg::GAIN_W;
  localparam int unsigned AccW  = DivW + GainW;
  localparam int unsigned MagW  = AccW - tfve_pkg::GAIN_FRAC_W;
  localparam int unsigned PosW  = tfve_pkg::POS_W;
  localparam int unsigned DiffW = PosW + 1;
  localparam int unsigned TimeW = tfve_pkg::TIME_W;
  localparam int unsigned SpdW  = tfve_pkg::SPEED_W;
  localparam int unsigned VelW  = tfve_pkg::VEL_W;
  localparam int unsigned IterW = $clog2(DivW);

  localparam logic [IdxW-1:0]  LastSlot = IdxW'(HistoryDepth - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(HistoryDepth);
  localparam logic [CntW-1:0]  SpanCnt  = CntW'(Span);
  localparam logic [CntW-1:0]  OneCnt   = CntW'(1);

  tfve_pkg::state_e state_q, state_d;
  tfve_pkg::op_e    op;

  logic                 recording_q;
  logic [IdxW-1:0]      newest_q;
  logic [CntW-1:0]      count_q;
  logic [SpdW-1:0]      thr_q, max_q;
  logic [tfve_pkg::PROP_W-1:0] prop_q;

  logic [TimeW-1:0]     time_q;
  logic [GainW-1:0]     gain_q;
  logic [PosW-1:0]      newx_q, newy_q;
  logic [DiffW-1:0]     dx_q, dy_q;
  logic [ElapW-1:0]     e_q;
  logic [DivW-1:0]      numx_q, numy_q;
  logic [DsrW-1:0]      remx_q, remy_q, dsr_q;
  logic                 negx_q, negy_q, ezero_q, dxnz_q, dynz_q;
  logic [AccW-1:0]      accx_q, accy_q;
  logic [GainW-1:0]     gsh_q;
  logic [IterW-1:0]     iter_q;
  logic                 m_valid_q;
  logic [VelW-1:0]      velx_q, vely_q;

  logic                 s_accept, store, out_load, result_present;
  logic [IdxW-1:0]      next_slot, older, raddr, waddr;
  logic [CntW-1:0]      back;
  logic [WrapW-1:0]     wrap_sum;
  logic [RamW-1:0]      rdata;
  logic [PosW-1:0]      in_x, in_y;
  logic [TimeW-1:0]     in_t;
  logic [GainW-1:0]     in_gain;

  assign in_x    = s_axis_tdata[PosW-1:0];
  assign in_y    = s_axis_tdata[2*PosW-1:PosW];
  assign in_t    = s_axis_tdata[RamW-1:2*PosW];
  assign in_gain = s_axis_tdata[RamW+GainW-1:RamW];
  assign op      = tfve_pkg::op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == tfve_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign store = s_accept && ((op == tfve_pkg::OP_TOUCH_DOWN) ||
                              (op == tfve_pkg::OP_TOUCH_MOVE && recording_q));

  assign next_slot = (newest_q == LastSlot) ? '0 : newest_q + IdxW'(1);
  assign waddr     = (op == tfve_pkg::OP_TOUCH_DOWN) ? '0 : next_slot;

  assign back     = ((count_q < SpanCnt) ? count_q : SpanCnt) - OneCnt;
  assign wrap_sum = {1'b0, newest_q} + WrapW'(HistoryDepth) - WrapW'(back);
  assign older    = ({1'b0, newest_q} >= WrapW'(back))
                  ? IdxW'({1'b0, newest_q} - WrapW'(back)) : wrap_sum[IdxW-1:0];
  assign raddr    = (state_q == tfve_pkg::ST_RD_NEW) ? newest_q : older;

  tfve_ram #(
    .Width (RamW),
    .Depth (HistoryDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata[RamW-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Difference and elapsed time against the older sample
  logic [PosW-1:0]  oldx, oldy;
  logic [TimeW-1:0] oldt;
  logic [ElapW-1:0] e_raw, e_alt;
  logic [DiffW-1:0] dx_d, dy_d;

  assign oldx  = rdata[PosW-1:0];
  assign oldy  = rdata[2*PosW-1:PosW];
  assign oldt  = rdata[RamW-1:2*PosW];
  assign dx_d  = {newx_q[PosW-1], newx_q} - {oldx[PosW-1], oldx};
  assign dy_d  = {newy_q[PosW-1], newy_q} - {oldy[PosW-1], oldy};
  assign e_alt = ElapW'(time_q) - ElapW'(oldt);
  assign e_raw = e_alt - ElapW'(prop_q);

  // Magnitudes for the divider
  logic [DiffW-1:0] magdx, magdy;
  logic [ElapW-1:0] mage;

  assign magdx = dx_q[DiffW-1] ? (~dx_q + DiffW'(1)) : dx_q;
  assign magdy = dy_q[DiffW-1] ? (~dy_q + DiffW'(1)) : dy_q;
  assign mage  = e_q[ElapW-1] ? (~e_q + ElapW'(1)) : e_q;

  // One restoring step per axis
  logic [DsrW:0]   shx, shy;
  logic [DsrW+1:0] trx, try_;
  logic            qbx, qby;

  assign shx  = {remx_q, numx_q[DivW-1]};
  assign shy  = {remy_q, numy_q[DivW-1]};
  assign trx  = {1'b0, shx} - {2'b0, dsr_q};
  assign try_ = {1'b0, shy} - {2'b0, dsr_q};
  assign qbx  = !trx[DsrW+1];
  assign qby  = !try_[DsrW+1];

  // Shaping of the scaled speed
  logic [MagW-1:0] gx, gy;
  logic [SpdW-1:0] sx, sy;
  logic            gain_nz;

  assign gx      = accx_q[AccW-1:tfve_pkg::GAIN_FRAC_W];
  assign gy      = accy_q[AccW-1:tfve_pkg::GAIN_FRAC_W];
  assign gain_nz = (gain_q != '0);

  always_comb begin
    if (ezero_q) begin
      sx = (dxnz_q && gain_nz) ? max_q : '0;
      sy = (dynz_q && gain_nz) ? max_q : '0;
      result_present = gain_nz && (dxnz_q || dynz_q);
    end else begin
      sx = (gx < MagW'(thr_q)) ? '0 : ((gx > MagW'(max_q)) ? max_q : gx[SpdW-1:0]);
      sy = (gy < MagW'(thr_q)) ? '0 : ((gy > MagW'(max_q)) ? max_q : gy[SpdW-1:0]);
      result_present = (gx != '0) || (gy != '0);
    end
  end

  assign out_load = (state_q == tfve_pkg::ST_OUT) && result_present &&
                    (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tfve_pkg::ST_IDLE: begin
        if (s_accept && op == tfve_pkg::OP_FLICK && recording_q && count_q > OneCnt) begin
          state_d = tfve_pkg::ST_RD_NEW;
        end
      end
      tfve_pkg::ST_RD_NEW: state_d = tfve_pkg::ST_RD_OLD;
      tfve_pkg::ST_RD_OLD: state_d = tfve_pkg::ST_DIFF;
      tfve_pkg::ST_DIFF:   state_d = tfve_pkg::ST_PREP;
      tfve_pkg::ST_PREP:   state_d = tfve_pkg::ST_DIV;
      tfve_pkg::ST_DIV: begin
        if (iter_q == IterW'(DivW - 1)) begin
          state_d = tfve_pkg::ST_MUL;
        end
      end
      tfve_pkg::ST_MUL: begin
        if (iter_q == IterW'(GainW - 1)) begin
          state_d = tfve_pkg::ST_OUT;
        end
      end
      tfve_pkg::ST_OUT: begin
        if (!result_present || out_load) begin
          state_d = tfve_pkg::ST_IDLE;
        end
      end
      default: state_d = tfve_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfve_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recording_q <= 1'b0;
      newest_q    <= LastSlot;
      count_q     <= '0;
      thr_q       <= tfve_pkg::THRESHOLD_RST;
      max_q       <= tfve_pkg::MAX_SPEED_RST;
      prop_q      <= tfve_pkg::PROP_RST;
      iter_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tfve_pkg::CFG_FLICK_THRESHOLD: thr_q  <= cfg_data_i;
          tfve_pkg::CFG_FLICK_MAX_SPEED: max_q  <= cfg_data_i;
          tfve_pkg::CFG_PROPAGATION_MS:  prop_q <= cfg_data_i[tfve_pkg::PROP_W-1:0];
          default: ;
        endcase
      end
      if (s_accept) begin
        case (op)
          tfve_pkg::OP_TOUCH_DOWN: begin
            recording_q <= 1'b1;
            newest_q    <= '0;
            count_q     <= OneCnt;
          end
          tfve_pkg::OP_TOUCH_MOVE: begin
            if (recording_q) begin
              newest_q <= next_slot;
              if (count_q < DepthCnt) begin
                count_q <= count_q + OneCnt;
              end
            end
          end
          tfve_pkg::OP_SECOND_DOWN: recording_q <= 1'b0;
          tfve_pkg::OP_FLICK:       recording_q <= 1'b0;
          default: ;
        endcase
      end
      if (state_q == tfve_pkg::ST_PREP ||
          (state_q == tfve_pkg::ST_DIV && iter_q == IterW'(DivW - 1))) begin
        iter_q <= '0;
      end else if (state_q == tfve_pkg::ST_DIV || state_q == tfve_pkg::ST_MUL) begin
        iter_q <= iter_q + IterW'(1);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tfve_pkg::ST_IDLE: begin
        time_q <= in_t;
        gain_q <= in_gain;
      end
      tfve_pkg::ST_RD_OLD: begin
        newx_q <= rdata[PosW-1:0];
        newy_q <= rdata[2*PosW-1:PosW];
      end
      tfve_pkg::ST_DIFF: begin
        dx_q <= dx_d;
        dy_q <= dy_d;
        e_q  <= e_raw[ElapW-1] ? e_alt : e_raw;
      end
      tfve_pkg::ST_PREP: begin
        numx_q  <= DivW'(magdx) * DivW'(tfve_pkg::MS_PER_S);
        numy_q  <= DivW'(magdy) * DivW'(tfve_pkg::MS_PER_S);
        dsr_q   <= mage[DsrW-1:0];
        remx_q  <= '0;
        remy_q  <= '0;
        negx_q  <= dx_q[DiffW-1] ^ e_q[ElapW-1];
        negy_q  <= dy_q[DiffW-1] ^ e_q[ElapW-1];
        ezero_q <= (e_q == '0);
        dxnz_q  <= (dx_q != '0);
        dynz_q  <= (dy_q != '0);
      end
      tfve_pkg::ST_DIV: begin
        remx_q <= qbx ? trx[DsrW-1:0] : shx[DsrW-1:0];
        remy_q <= qby ? try_[DsrW-1:0] : shy[DsrW-1:0];
        numx_q <= {numx_q[DivW-2:0], qbx};
        numy_q <= {numy_q[DivW-2:0], qby};
        accx_q <= '0;
        accy_q <= '0;
        gsh_q  <= gain_q;
      end
      tfve_pkg::ST_MUL: begin
        accx_q <= {accx_q[AccW-2:0], 1'b0} + (gsh_q[GainW-1] ? AccW'(numx_q) : '0);
        accy_q <= {accy_q[AccW-2:0], 1'b0} + (gsh_q[GainW-1] ? AccW'(numy_q) : '0);
        gsh_q  <= {gsh_q[GainW-2:0], 1'b0};
      end
      tfve_pkg::ST_OUT: begin
        if (out_load) begin
          velx_q <= negx_q ? (~{1'b0, sx} + VelW'(1)) : {1'b0, sx};
          vely_q <= negy_q ? (~{1'b0, sy} + VelW'(1)) : {1'b0, sy};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(tfve_pkg::OUT_DATA_W - 2 * VelW)'(0), vely_q, velx_q};

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("sample count beyond ring depth");

  a_down_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && op == tfve_pkg::OP_TOUCH_DOWN |=> recording_q && count_q == OneCnt)
    else $error("touch down did not restart recording");

  a_idle_flick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && op == tfve_pkg::OP_FLICK && !recording_q |=> state_q == tfve_pkg::ST_IDLE)
    else $error("flick started while not recording");

  a_div_iter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tfve_pkg::ST_DIV |-> iter_q <= IterW'(DivW - 1))
    else $error("divider step count overran");

endmodule
